FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file nmp_checker.sv.
// Clock and active-low reset are passed in by the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/nmp_pkg.sv
// Types and constants of the NATS message parser.
// No dependencies.
`timescale 1ns / 1ps

package nmp_pkg;

  localparam int MAX_TOKENS = 4;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_SP  = 8'h20;

  // verb indexes, ordered as they are matched
  localparam logic [2:0] VERB_PING    = 3'd0;
  localparam logic [2:0] VERB_PONG    = 3'd1;
  localparam logic [2:0] VERB_OK      = 3'd2;
  localparam logic [2:0] VERB_ERR     = 3'd3;
  localparam logic [2:0] VERB_INFO    = 3'd4;
  localparam logic [2:0] VERB_MSG     = 3'd5;
  localparam logic [2:0] VERB_UNKNOWN = 3'd6;

  localparam logic [20:0] PAYLOAD_MAX_RESET = 21'd1048576;

  typedef enum logic [3:0] {
    MT_PING      = 4'd0,
    MT_PONG      = 4'd1,
    MT_OK        = 4'd2,
    MT_ERR       = 4'd3,
    MT_INFO      = 4'd4,
    MT_MSG       = 4'd5,
    MT_UNKNOWN   = 4'd6,
    MT_MALFORMED = 4'd7,
    MT_TOO_LONG  = 4'd8
  } msg_type_e;

  typedef struct packed {
    msg_type_e   msg_type;
    logic [11:0] text_offset;
    logic [11:0] text_length;
    logic [11:0] sid_offset;
    logic [11:0] sid_length;
    logic [11:0] reply_offset;
    logic [11:0] reply_length;
    logic        has_reply;
    logic [20:0] payload_length;
    logic [20:0] message_length;
  } res_t;

  function automatic logic [2:0] verb_len(logic [2:0] v);
    unique case (v)
      VERB_OK, VERB_MSG: return 3'd3;
      default:           return 3'd4;
    endcase
  endfunction

  function automatic logic [7:0] verb_char(logic [2:0] v, logic [1:0] idx);
    logic [31:0] txt;
    unique case (v)
      VERB_PING: txt = "PING";
      VERB_PONG: txt = "PONG";
      VERB_OK:   txt = {"+OK", 8'h00};
      VERB_ERR:  txt = "-ERR";
      VERB_INFO: txt = "INFO";
      VERB_MSG:  txt = {"MSG", 8'h00};
      default:   txt = '0;
    endcase
    unique case (idx)
      2'd0:    return txt[31:24];
      2'd1:    return txt[23:16];
      2'd2:    return txt[15:8];
      default: return txt[7:0];
    endcase
  endfunction

endpackage

FILE: rtl/core/nats_message_parser_top.sv
// Top level of the NATS message parser: parser core plus output buffer.
// Depends on nmp_pkg, nmp_parser, nmp_out_buf.
//
// Usage:
//   Input channel: one stream byte per beat on data_byte_i, accepted when
//   in_valid_i is high and in_stall_o is low. One byte per cycle sustained while in_stall_o is low.
//   Output channel: one beat per finished message (PING, PONG, +OK, -ERR,
//   INFO, MSG, unknown, malformed MSG, over-long line), taken when
//   out_valid_o is high and out_stall_i is low.
//   Result: the byte that completes it (the LF of a non-MSG line, the last
//   trailer byte of a MSG) loads it into the output register or skid beat.
//   Each byte is handled in the cycle it is accepted; the per-byte state
//   update is the only loop, so throughput is one byte per cycle unless stalled.
//   Stall: the output register plus a one-beat skid keep bytes flowing while
//   a result waits; in_stall_o rises only while the skid beat is held, and
//   drops the cycle after out_stall_i releases.
//   Config: cfg_we_i writes max_payload_bytes from cfg_wdata_i; write only
//   while idle.
//   Reset: parser returns to the start of a control line, max_payload_bytes
//   to 1048576, output empty.
`timescale 1ns / 1ps

module nats_message_parser_top
  import nmp_pkg::*;
#(
  parameter int MAX_LINE_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        cfg_we_i,
  input  logic [20:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  msg_type_o,
  output logic [11:0] text_offset_o,
  output logic [11:0] text_length_o,
  output logic [11:0] sid_offset_o,
  output logic [11:0] sid_length_o,
  output logic [11:0] reply_offset_o,
  output logic [11:0] reply_length_o,
  output logic        has_reply_o,
  output logic [20:0] payload_length_o,
  output logic [20:0] message_length_o
);

  logic accept;
  logic res_valid;
  res_t res, out;

  assign accept = in_valid_i && !in_stall_o;

  nmp_parser #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  nmp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out),
    .in_stall_o  (in_stall_o)
  );

  assign msg_type_o       = out.msg_type;
  assign text_offset_o    = out.text_offset;
  assign text_length_o    = out.text_length;
  assign sid_offset_o     = out.sid_offset;
  assign sid_length_o     = out.sid_length;
  assign reply_offset_o   = out.reply_offset;
  assign reply_length_o   = out.reply_length;
  assign has_reply_o      = out.has_reply;
  assign payload_length_o = out.payload_length;
  assign message_length_o = out.message_length;

endmodule

FILE: rtl/core/nmp_parser.sv
// Per-byte parser state and result generation.
// Depends on nmp_pkg.
`timescale 1ns / 1ps

module nmp_parser
  import nmp_pkg::*;
#(
  parameter int MAX_LINE_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        cfg_we_i,
  input  logic [20:0] cfg_wdata_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  localparam int PW = $clog2(MAX_LINE_BYTES);

  localparam logic [1:0] PH_LINE    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_TRAILER = 2'd2;

  typedef struct packed {
    logic [PW-1:0]                   pos;
    logic                            ovf;
    logic [5:0]                      cand;
    logic                            in_tok;
    logic [2:0]                      tcnt;
    logic [MAX_TOKENS-1:0][11:0]     toff;
    logic [MAX_TOKENS-1:0][11:0]     tlen;
    logic [20:0]                     dval;
    logic                            dvalid;
    logic [PW-1:0]                   aoff;
    logic                            askip;
  } line_t;

  function automatic logic [11:0] fit12(logic [PW-1:0] x);
    logic [PW+11:0] e;
    e = {12'b0, x};
    return e[11:0];
  endfunction

  // token arrays are left as they are
  function automatic line_t new_line(line_t s);
    line_t r;
    r        = s;
    r.pos    = '0;
    r.ovf    = 1'b0;
    r.cand   = '1;
    r.in_tok = 1'b0;
    r.tcnt   = '0;
    r.dval   = '0;
    r.dvalid = 1'b1;
    r.aoff   = '0;
    r.askip  = 1'b1;
    return r;
  endfunction

  // one byte of line content
  function automatic line_t content(line_t s, logic [7:0] c);
    line_t       r;
    logic        blank;
    logic [2:0]  vl;
    logic [1:0]  idx;
    logic [24:0] dv;
    logic [24:0] dnext;
    r     = s;
    blank = (c == CHAR_SP) || (c == CHAR_TAB);
    if (s.pos >= PW'(MAX_LINE_BYTES - 1)) begin
      r.ovf = 1'b1;
    end else begin
      for (int v = 0; v < 6; v++) begin
        vl = verb_len(3'(v));
        if (s.pos < PW'(vl)) begin
          if (c != verb_char(3'(v), s.pos[1:0])) r.cand[v] = 1'b0;
        end else if (s.pos == PW'(vl) && !blank) begin
          r.cand[v] = 1'b0;
        end
      end
      if (s.pos >= PW'(4) && s.askip && !blank) begin
        r.aoff  = s.pos;
        r.askip = 1'b0;
      end
      if (s.pos >= PW'(3)) begin
        if (blank) begin
          r.in_tok = 1'b0;
        end else if (s.in_tok) begin
          idx         = s.tcnt[1:0] - 2'd1;
          r.tlen[idx] = s.tlen[idx] + 12'd1;
        end else if (s.tcnt < 3'(MAX_TOKENS)) begin
          idx         = s.tcnt[1:0];
          r.toff[idx] = fit12(s.pos);
          r.tlen[idx] = 12'd1;
          r.tcnt      = s.tcnt + 3'd1;
          r.in_tok    = 1'b1;
          r.dval      = '0;
          r.dvalid    = 1'b1;
        end
        if (r.in_tok && r.dvalid) begin
          if (c >= "0" && c <= "9") begin
            dv    = {4'b0, r.dval};
            dnext = (dv << 3) + (dv << 1) + {21'b0, c[3:0]};
            if (dnext > 25'h1FFFFF) r.dvalid = 1'b0;
            else r.dval = dnext[20:0];
          end else begin
            r.dvalid = 1'b0;
          end
        end
      end
      r.pos = s.pos + PW'(1);
    end
    return r;
  endfunction

  logic [1:0]  phase_q, phase_d;
  line_t       st_q, st_d;
  logic        cr_q, cr_d;
  logic [20:0] seen_q, seen_d;
  logic [20:0] rem_q, rem_d;
  logic [1:0]  trl_q, trl_d;
  logic [20:0] max_pay_q;

  always_comb begin
    line_t       l1;
    logic [20:0] seen_nx;
    logic [PW-1:0] len;
    logic [PW-1:0] a;
    logic [2:0]  mv;
    logic [22:0] tot;
    logic        bad;
    phase_d     = phase_q;
    st_d        = st_q;
    cr_d        = cr_q;
    seen_d      = seen_q;
    rem_d       = rem_q;
    trl_d       = trl_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    l1          = st_q;
    seen_nx     = (seen_q == '1) ? seen_q : seen_q + 21'd1;
    len         = st_q.pos;
    a           = st_q.askip ? len : st_q.aoff;
    tot         = 23'(st_q.pos) + 23'd4 + {2'b0, st_q.dval};
    bad         = (st_q.tcnt != 3'd3 && st_q.tcnt != 3'd4) || !st_q.dvalid ||
                  (st_q.dval > max_pay_q);
    mv          = VERB_UNKNOWN;
    for (int v = 5; v >= 0; v--) begin
      if (st_q.cand[v] && len >= PW'(verb_len(3'(v)))) mv = 3'(v);
    end

    if (accept_i) begin
      unique case (phase_q)
        PH_PAYLOAD: begin
          rem_d = rem_q - 21'd1;
          if (rem_d == '0) phase_d = PH_TRAILER;
        end
        PH_TRAILER: begin
          trl_d = trl_q - 2'd1;
          if (trl_d == '0) begin
            res_valid_o          = 1'b1;
            res_o.msg_type       = MT_MSG;
            res_o.message_length = tot[22:21] != 2'b0 ? '1 : tot[20:0];
            res_o.text_offset    = st_q.toff[0];
            res_o.text_length    = st_q.tlen[0];
            res_o.sid_offset     = st_q.toff[1];
            res_o.sid_length     = st_q.tlen[1];
            if (st_q.tcnt == 3'd4) begin
              res_o.reply_offset = st_q.toff[2];
              res_o.reply_length = st_q.tlen[2];
              res_o.has_reply    = 1'b1;
            end
            res_o.payload_length = st_q.dval;
            st_d    = new_line(st_q);
            phase_d = PH_LINE;
            cr_d    = 1'b0;
            seen_d  = '0;
            rem_d   = '0;
            trl_d   = '0;
          end
        end
        PH_LINE: begin
          seen_d = seen_nx;
          if (cr_q && data_byte_i == CHAR_LF) begin
            res_valid_o          = 1'b1;
            res_o.message_length = 21'(len) + 21'd2;
            if (st_q.ovf) begin
              res_o.msg_type       = MT_TOO_LONG;
              res_o.message_length = seen_nx;
            end else if (mv == VERB_ERR || mv == VERB_INFO) begin
              res_o.msg_type    = msg_type_e'({1'b0, mv});
              res_o.text_offset = fit12(a);
              res_o.text_length = fit12(len - a);
            end else if (mv != VERB_MSG) begin
              res_o.msg_type = msg_type_e'({1'b0, mv});
            end else if (bad) begin
              res_o.msg_type = MT_MALFORMED;
            end else begin
              // good MSG line: payload and trailer follow, line state kept
              res_valid_o = 1'b0;
              rem_d       = st_q.dval;
              trl_d       = 2'd2;
              phase_d     = (st_q.dval == '0) ? PH_TRAILER : PH_PAYLOAD;
            end
            if (res_valid_o) begin
              st_d   = new_line(st_q);
              cr_d   = 1'b0;
              seen_d = '0;
            end
          end else begin
            // lone CR is content, and may land in the same beat as this byte
            if (cr_q && !st_q.ovf) l1 = content(st_q, CHAR_CR);
            cr_d = (data_byte_i == CHAR_CR);
            if (data_byte_i != CHAR_CR && !l1.ovf) st_d = content(l1, data_byte_i);
            else st_d = l1;
          end
        end
        default: begin
          st_d    = new_line(st_q);
          phase_d = PH_LINE;
          cr_d    = 1'b0;
          seen_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LINE;
      st_q      <= new_line(line_t'('0));
      cr_q      <= 1'b0;
      seen_q    <= '0;
      rem_q     <= '0;
      trl_q     <= '0;
      max_pay_q <= PAYLOAD_MAX_RESET;
    end else begin
      phase_q <= phase_d;
      st_q    <= st_d;
      cr_q    <= cr_d;
      seen_q  <= seen_d;
      rem_q   <= rem_d;
      trl_q   <= trl_d;
      if (cfg_we_i) max_pay_q <= cfg_wdata_i;
    end
  end

endmodule

FILE: rtl/core/nmp_out_buf.sv
// Result register with a one-entry skid stage.
// Depends on nmp_pkg.
`timescale 1ns / 1ps

module nmp_out_buf
  import nmp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  input  res_t res_i,
  input  logic out_stall_i,
  output logic out_valid_o,
  output res_t out_o,
  output logic in_stall_o
);

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  // upstream holds off only while the skid beat is parked
  assign in_stall_o  = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid_i) begin
      if (out_free) out_valid_q <= 1'b1;
      else skid_valid_q <= 1'b1;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) out_q <= skid_q;
    end else if (res_valid_i) begin
      if (out_free) out_q <= res_i;
      else skid_q <= res_i;
    end
  end

endmodule

FILE: rtl/core/nmp_checker.sv
// Port-level checks for the NATS message parser, bound to the top level.
// Depends on nmp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nmp_checker
  import nmp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  msg_type_o,
  input logic [11:0] reply_length_o,
  input logic        has_reply_o,
  input logic [20:0] payload_length_o,
  input logic [20:0] message_length_o
);

  // stalled result beat holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(msg_type_o) && $stable(message_length_o))

  // skid is drained the cycle after the receiver lets go
  `ASSERT_NEXT(a_skid_drain, clk_i, rst_ni, in_stall_o && !out_stall_i, !in_stall_o)

  // input stalls only behind a pending result
  `ASSERT_IMPLIES(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o)

  // reply and payload fields belong to MSG beats only
  `ASSERT_IMPLIES(a_msg_only, clk_i, rst_ni,
                  out_valid_o && (msg_type_o != MT_MSG),
                  !has_reply_o && (payload_length_o == '0) && (reply_length_o == '0))

endmodule

bind nats_message_parser_top nmp_checker u_nmp_checker (.*);
